// File: rtl/core/sle_pkg.sv
package sle_pkg;

	// Default table depth and fixed field widths.
	localparam int DEPTH_DEFAULT = 32;
	localparam int VALUE_W       = 32;
	localparam int OPCODE_W      = 2;
	localparam int STATUS_W      = 3;
	// Output tdata: status, then element, padded to whole bytes.
	localparam int OUT_TDATA_W   = 40;
	localparam int OUT_PAD_W     = OUT_TDATA_W - STATUS_W - VALUE_W;

	typedef enum logic [OPCODE_W-1:0] {
		OP_INSERT    = 2'd0,
		OP_DELETE    = 2'd1,
		OP_READ_ASC  = 2'd2,
		OP_READ_DESC = 2'd3
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE      = 3'd0,
		ST_NOT_FOUND = 3'd1,
		ST_FULL      = 3'd2,
		ST_ELEMENT   = 3'd3,
		ST_EMPTY     = 3'd4
	} status_t;

	// One result beat handed from the sequencer to the output register.
	typedef struct packed {
		logic               valid;
		status_t            status;
		logic [VALUE_W-1:0] element;
		logic               last;
	} beat_t;

endpackage

// File: rtl/core/sorted_list_engine.sv
// Channel  | Direction | Beat content
// s_axis   | in        | tdata[31:0] value (signed); tuser[1:0] opcode
// m_axis   | out       | tdata[2:0] status, tdata[34:3] element, tdata[39:35] zero;
//          |           | tlast marks the final result of an item
//
// One item at a time: s_axis_tready is high only while the sequencer is idle.
// Insert shifts the entries above the insertion point up, from the top down; delete
// scans up for a match, then shifts those above it down. Both are set by the single
// table read port, whose data is registered. A read-out reads each entry, then emits it.
// Reset (arst_n low) empties the table; the table contents need no clearing.
// A stalled m_axis holds the sequencer at its next result; the output register
// lets the next result be prepared while the current beat waits.
module sorted_list_engine #(
	parameter int DEPTH = sle_pkg::DEPTH_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [sle_pkg::VALUE_W-1:0]     s_axis_tdata,  // [31:0] value
	input  logic [sle_pkg::OPCODE_W-1:0]    s_axis_tuser,  // [1:0] opcode
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [sle_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // [2:0] status, [34:3] element
	output logic                            m_axis_tlast
);

	localparam int AW = $clog2(DEPTH);

	sle_pkg::beat_t              beat;
	logic                        out_free;
	logic                        mem_we;
	logic [AW-1:0]               mem_waddr;
	logic [sle_pkg::VALUE_W-1:0] mem_wdata;
	logic                        mem_re;
	logic [AW-1:0]               mem_raddr;
	logic [sle_pkg::VALUE_W-1:0] mem_rdata;

	logic                        out_valid_q;
	sle_pkg::status_t            out_status_q;
	logic [sle_pkg::VALUE_W-1:0] out_element_q;
	logic                        out_last_q;

	// The sequencer may hand over a new beat when the output register is
	// empty or its current beat leaves in this cycle.
	assign out_free = !out_valid_q || m_axis_tready;

	sle_seq #(
		.DEPTH(DEPTH)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_opcode(sle_pkg::opcode_t'(s_axis_tuser)),
		.in_value (s_axis_tdata),
		.out_free (out_free),
		.beat     (beat),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_re   (mem_re),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	sle_mem #(
		.DEPTH(DEPTH)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// Output register: loads a beat from the sequencer, clears once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q   <= 1'b0;
			out_status_q  <= sle_pkg::ST_DONE;
			out_element_q <= '0;
			out_last_q    <= 1'b0;
		end else if (beat.valid) begin
			out_valid_q   <= 1'b1;
			out_status_q  <= beat.status;
			out_element_q <= beat.element;
			out_last_q    <= beat.last;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{sle_pkg::OUT_PAD_W{1'b0}}, out_element_q, out_status_q};
	assign m_axis_tlast  = out_last_q;

endmodule

// File: rtl/core/sle_mem.sv
module sle_mem #(
	parameter int DEPTH = sle_pkg::DEPTH_DEFAULT
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  logic [sle_pkg::VALUE_W-1:0] wdata,
	input  logic                       re,
	input  logic [$clog2(DEPTH)-1:0]   raddr,
	output logic [sle_pkg::VALUE_W-1:0] rdata
);

	logic [sle_pkg::VALUE_W-1:0] mem [DEPTH];
	logic [sle_pkg::VALUE_W-1:0] rdata_q;

	// One write port, one read port; read data is registered and holds while re is low.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/core/sle_seq.sv
module sle_seq #(
	parameter int DEPTH = sle_pkg::DEPTH_DEFAULT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  sle_pkg::opcode_t            in_opcode,
	input  logic [sle_pkg::VALUE_W-1:0] in_value,
	input  logic                        out_free,
	output sle_pkg::beat_t              beat,
	output logic                        mem_we,
	output logic [$clog2(DEPTH)-1:0]    mem_waddr,
	output logic [sle_pkg::VALUE_W-1:0] mem_wdata,
	output logic                        mem_re,
	output logic [$clog2(DEPTH)-1:0]    mem_raddr,
	input  logic [sle_pkg::VALUE_W-1:0] mem_rdata
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [3:0] {
		S_IDLE,
		S_INS_RD,
		S_INS_CMP,
		S_DEL_RD,
		S_DEL_CMP,
		S_SHF_RD,
		S_SHF_WR,
		S_OUT_RD,
		S_OUT_EMIT,
		S_RESP
	} state_t;

	state_t                      state_q;
	logic [CW-1:0]               count_q;
	logic [CW-1:0]               idx_q;
	sle_pkg::opcode_t            op_q;
	logic [sle_pkg::VALUE_W-1:0] val_q;
	sle_pkg::status_t            status_q;

	logic [CW-1:0] idx_m1;
	logic [CW-1:0] idx_p1;
	logic [CW-1:0] idx_rev;
	logic          lt;
	logic          eq;
	logic          full;

	assign idx_m1  = idx_q - 1'b1;
	assign idx_p1  = idx_q + 1'b1;
	assign idx_rev = count_q - 1'b1 - idx_q;
	assign full    = (count_q == CW'(DEPTH));

	// The shared comparator: stored entry against the item's value.
	assign lt = $signed(mem_rdata) < $signed(val_q);
	assign eq = (mem_rdata == val_q);

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q[AW-1:0];
		mem_wdata = val_q;
		mem_re    = 1'b0;
		mem_raddr = idx_q[AW-1:0];
		beat      = '0;
		beat.status = sle_pkg::ST_DONE;
		case (state_q)
			S_INS_RD: begin
				if (idx_q == '0) begin
					mem_we = 1'b1;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = idx_m1[AW-1:0];
				end
			end
			S_INS_CMP: begin
				mem_we    = 1'b1;
				mem_wdata = lt ? val_q : mem_rdata;
			end
			S_DEL_RD: begin
				mem_re = (idx_q != count_q);
			end
			S_SHF_RD: begin
				mem_re    = (idx_p1 < count_q);
				mem_raddr = idx_p1[AW-1:0];
			end
			S_SHF_WR: begin
				mem_we    = 1'b1;
				mem_wdata = mem_rdata;
			end
			S_OUT_RD: begin
				mem_re    = 1'b1;
				mem_raddr = (op_q == sle_pkg::OP_READ_ASC) ? idx_q[AW-1:0] : idx_rev[AW-1:0];
			end
			S_OUT_EMIT: begin
				beat.valid   = out_free;
				beat.status  = sle_pkg::ST_ELEMENT;
				beat.element = mem_rdata;
				beat.last    = (idx_p1 == count_q);
			end
			S_RESP: begin
				beat.valid  = out_free;
				beat.status = status_q;
				beat.last   = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			idx_q    <= '0;
			op_q     <= sle_pkg::OP_INSERT;
			val_q    <= '0;
			status_q <= sle_pkg::ST_DONE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q  <= in_opcode;
						val_q <= in_value;
						case (in_opcode)
							sle_pkg::OP_INSERT: begin
								if (full) begin
									status_q <= sle_pkg::ST_FULL;
									state_q  <= S_RESP;
								end else begin
									idx_q   <= count_q;
									state_q <= S_INS_RD;
								end
							end
							sle_pkg::OP_DELETE: begin
								idx_q   <= '0;
								state_q <= S_DEL_RD;
							end
							default: begin
								if (count_q == '0) begin
									status_q <= sle_pkg::ST_EMPTY;
									state_q  <= S_RESP;
								end else begin
									idx_q   <= '0;
									state_q <= S_OUT_RD;
								end
							end
						endcase
					end
				end
				S_INS_RD: begin
					if (idx_q == '0) begin
						count_q  <= count_q + 1'b1;
						status_q <= sle_pkg::ST_DONE;
						state_q  <= S_RESP;
					end else begin
						state_q <= S_INS_CMP;
					end
				end
				S_INS_CMP: begin
					if (lt) begin
						count_q  <= count_q + 1'b1;
						status_q <= sle_pkg::ST_DONE;
						state_q  <= S_RESP;
					end else begin
						idx_q   <= idx_m1;
						state_q <= S_INS_RD;
					end
				end
				S_DEL_RD: begin
					if (idx_q == count_q) begin
						status_q <= sle_pkg::ST_NOT_FOUND;
						state_q  <= S_RESP;
					end else begin
						state_q <= S_DEL_CMP;
					end
				end
				S_DEL_CMP: begin
					if (eq) begin
						state_q <= S_SHF_RD;
					end else begin
						idx_q   <= idx_p1;
						state_q <= S_DEL_RD;
					end
				end
				S_SHF_RD: begin
					if (idx_p1 >= count_q) begin
						count_q  <= count_q - 1'b1;
						status_q <= sle_pkg::ST_DONE;
						state_q  <= S_RESP;
					end else begin
						state_q <= S_SHF_WR;
					end
				end
				S_SHF_WR: begin
					idx_q   <= idx_p1;
					state_q <= S_SHF_RD;
				end
				S_OUT_RD: begin
					state_q <= S_OUT_EMIT;
				end
				S_OUT_EMIT: begin
					if (out_free) begin
						if (idx_p1 == count_q) begin
							state_q <= S_IDLE;
						end else begin
							idx_q   <= idx_p1;
							state_q <= S_OUT_RD;
						end
					end
				end
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count exceeds table depth");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == $past(count_q)) || (count_q == CW'($past(count_q) + 1'b1)) ||
		(count_q == CW'($past(count_q) - 1'b1)))
		else $error("entry count moved by more than one");

	a_full_refuse: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (in_opcode == sle_pkg::OP_INSERT) && full)
		|=> (state_q == S_RESP) && (status_q == sle_pkg::ST_FULL) && full)
		else $error("insert into full table not refused");

	a_beat_slot: assert property (@(posedge clk) disable iff (!arst_n)
		beat.valid |-> out_free)
		else $error("beat issued while output register is occupied");
`endif

endmodule

// File: tb/tb.sv
module tb;
	import sle_pkg::*;

	localparam int DEPTH       = DEPTH_DEFAULT;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int SETTLE_CYC  = 4 * DEPTH + 40;
	localparam int REPORT_MAX  = 10;

	localparam logic [VALUE_W-1:0] VAL_MIN  = 32'h8000_0000;
	localparam logic [VALUE_W-1:0] VAL_MAX  = 32'h7FFF_FFFF;
	localparam logic [VALUE_W-1:0] VAL_ZERO = 32'h0000_0000;
	localparam logic [VALUE_W-1:0] VAL_NEG1 = 32'hFFFF_FFFF;

	typedef struct {
		status_t            status;
		logic [VALUE_W-1:0] element;
		logic               last;
	} list_result_t;

	logic                   clk           = 1'b0;
	logic                   arst_n        = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [VALUE_W-1:0]     s_axis_tdata  = '0;
	logic [OPCODE_W-1:0]    s_axis_tuser  = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tlast;

	// Shadow copy of the sorted list and the results it predicts.
	logic signed [VALUE_W-1:0] stored_values [DEPTH];
	int                        stored_count = 0;
	list_result_t              pending_results [$];

	int fail_count      = 0;
	int cycle_count     = 0;
	int send_idle_pct   = 0;
	int recv_stall_pct  = 0;
	int hold_off_cycles = 0;

	sorted_list_engine #(
		.DEPTH(DEPTH)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_results.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic void queue_result(input status_t st, input logic [VALUE_W-1:0] elem,
			input logic last);
		list_result_t r;
		r.status  = st;
		r.element = elem;
		r.last    = last;
		pending_results.push_back(r);
	endfunction

	// Applies one accepted list operation to the shadow list and queues its results.
	function automatic void apply_list_op(input opcode_t op, input logic [VALUE_W-1:0] v);
		int pos;
		int i;
		int idx;
		pos = 0;
		case (op)
			OP_INSERT: begin
				if (stored_count >= DEPTH) begin
					queue_result(ST_FULL, '0, 1'b1);
				end else begin
					while (pos < stored_count && stored_values[pos] < $signed(v))
						pos++;
					for (i = stored_count; i > pos; i--)
						stored_values[i] = stored_values[i-1];
					stored_values[pos] = v;
					stored_count++;
					queue_result(ST_DONE, '0, 1'b1);
				end
			end
			OP_DELETE: begin
				while (pos < stored_count && stored_values[pos] != v)
					pos++;
				if (pos >= stored_count) begin
					queue_result(ST_NOT_FOUND, '0, 1'b1);
				end else begin
					for (i = pos; i + 1 < stored_count; i++)
						stored_values[i] = stored_values[i+1];
					stored_count--;
					queue_result(ST_DONE, '0, 1'b1);
				end
			end
			default: begin
				if (stored_count == 0) begin
					queue_result(ST_EMPTY, '0, 1'b1);
				end else begin
					for (i = 0; i < stored_count; i++) begin
						idx = (op == OP_READ_ASC) ? i : stored_count - 1 - i;
						queue_result(ST_ELEMENT, stored_values[idx], i == stored_count - 1);
					end
				end
			end
		endcase
	endfunction

	// Input beats are predicted before output beats are checked in the same edge.
	always @(posedge clk) begin
		list_result_t       want;
		status_t            got_status;
		logic [VALUE_W-1:0] got_element;
		logic [OUT_PAD_W-1:0] got_pad;
		if (arst_n && s_axis_tvalid && s_axis_tready)
			apply_list_op(opcode_t'(s_axis_tuser), s_axis_tdata);
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_status  = status_t'(m_axis_tdata[STATUS_W-1:0]);
			got_element = m_axis_tdata[STATUS_W +: VALUE_W];
			got_pad     = m_axis_tdata[OUT_TDATA_W-1 -: OUT_PAD_W];
			if (pending_results.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_MAX)
					$display("unexpected result beat: status %0d element %0d last %0b",
						got_status, $signed(got_element), m_axis_tlast);
			end else begin
				want = pending_results.pop_front();
				if (got_status !== want.status || got_element !== want.element ||
						m_axis_tlast !== want.last || got_pad !== '0) begin
					fail_count++;
					if (fail_count <= REPORT_MAX)
						$display({"mismatch: expected status %0d element %0d last %0b, ",
							"got status %0d element %0d last %0b pad %h"},
							want.status, $signed(want.element), want.last,
							got_status, $signed(got_element), m_axis_tlast, got_pad);
				end
			end
		end
	end

	// Result side: random stalls, or a long hold-off when one is requested.
	always @(negedge clk) begin
		if (hold_off_cycles > 0) begin
			hold_off_cycles--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic set_idling(input int send_pct, input int recv_pct);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
	endtask

	// Moves to the next falling edge, inserting random sender gaps.
	task automatic wait_slot();
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
	endtask

	// Called at a falling edge; returns at the rising edge that takes the beat.
	task automatic offer_item(input opcode_t op, input logic [VALUE_W-1:0] v);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= v;
		s_axis_tuser  <= op;
		do
			@(posedge clk);
		while (!s_axis_tready);
	endtask

	task automatic send_item(input opcode_t op, input logic [VALUE_W-1:0] v);
		wait_slot();
		offer_item(op, v);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	// Mixes stored values (hits for delete, duplicates for insert), extremes,
	// a narrow band around zero and full-range values.
	function automatic logic [VALUE_W-1:0] pick_value(input bit prefer_stored);
		int r;
		r = $urandom_range(99);
		if (prefer_stored && stored_count > 0 && r < 70)
			return stored_values[$urandom_range(stored_count - 1)];
		r = $urandom_range(99);
		if (r < 15) begin
			case ($urandom_range(3))
				0:       return VAL_MIN;
				1:       return VAL_MAX;
				2:       return VAL_NEG1;
				default: return VAL_ZERO;
			endcase
		end
		if (r < 40)
			return int'($urandom_range(8)) - 4;
		return $urandom();
	endfunction

	task automatic test_directed();
		set_idling(0, 0);
		send_item(OP_READ_ASC, VAL_MAX);
		send_item(OP_READ_DESC, VAL_MIN);
		send_item(OP_DELETE, VAL_ZERO);
		send_item(OP_INSERT, VAL_ZERO);
		send_item(OP_INSERT, VAL_MAX);
		send_item(OP_INSERT, VAL_MIN);
		send_item(OP_INSERT, VAL_NEG1);
		send_item(OP_INSERT, 32'd1);
		// Equal values go ahead of their equals.
		send_item(OP_INSERT, VAL_ZERO);
		send_item(OP_INSERT, VAL_MAX);
		send_item(OP_READ_ASC, VAL_ZERO);
		send_item(OP_READ_DESC, VAL_ZERO);
		send_item(OP_DELETE, 32'd2);
		send_item(OP_DELETE, VAL_ZERO);
		send_item(OP_DELETE, VAL_MIN);
		send_item(OP_DELETE, VAL_MAX);
		send_item(OP_READ_ASC, VAL_NEG1);
		send_item(OP_DELETE, VAL_NEG1);
		send_item(OP_DELETE, 32'd1);
		send_item(OP_DELETE, VAL_ZERO);
		send_item(OP_DELETE, VAL_MAX);
		send_item(OP_READ_DESC, VAL_ZERO);
		wait_drained();
	endtask

	task automatic test_full_table();
		int k;
		logic [VALUE_W-1:0] v;
		set_idling(8, 8);
		wait_drained();
		for (k = stored_count; k < DEPTH; k++)
			send_item(OP_INSERT, pick_value($urandom_range(99) < 20));
		send_item(OP_INSERT, VAL_MAX);
		send_item(OP_INSERT, VAL_MIN);
		send_item(OP_READ_ASC, '0);
		send_item(OP_READ_DESC, '0);
		send_item(OP_DELETE, 32'h1234_5679);
		wait_drained();
		// Empty the full table again, one stored value at a time.
		for (k = 0; k < DEPTH; k++) begin
			wait_slot();
			v = stored_values[$urandom_range(stored_count - 1)];
			offer_item(OP_DELETE, v);
			@(negedge clk);
			if (k % 8 == 7)
				wait_drained();
		end
		send_item(OP_READ_ASC, '0);
		wait_drained();
	endtask

	// The result side holds off while items keep coming, so the block backs up.
	task automatic test_backpressure();
		int k;
		set_idling(0, 0);
		wait_drained();
		for (k = 0; k < 12; k++)
			send_item(OP_INSERT, pick_value(1'b0));
		hold_off_cycles = 400;
		send_item(OP_READ_ASC, '0);
		send_item(OP_INSERT, pick_value(1'b0));
		send_item(OP_READ_DESC, '0);
		send_item(OP_DELETE, pick_value(1'b1));
		send_item(OP_READ_ASC, '0);
		send_item(OP_DELETE, pick_value(1'b0));
		send_item(OP_READ_DESC, '0);
		wait_drained();
		while (hold_off_cycles > 0)
			@(negedge clk);
	endtask

	task automatic test_random();
		int phase;
		int n;
		int r;
		int ins_w;
		int del_w;
		opcode_t op;
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0:       set_idling(0, 0);
				1:       set_idling(85, 0);
				2:       set_idling(0, 85);
				default: set_idling(8, 8);
			endcase
			for (n = 0; n < 75; n++) begin
				// Pick filling or draining weights at random so both ends are reached.
				if (n % 50 == 0) begin
					if ($urandom_range(1)) begin
						ins_w = 60;
						del_w = 20;
					end else begin
						ins_w = 25;
						del_w = 55;
					end
				end
				wait_slot();
				r = $urandom_range(99);
				if (r < ins_w)
					op = OP_INSERT;
				else if (r < ins_w + del_w)
					op = OP_DELETE;
				else
					op = $urandom_range(1) ? OP_READ_ASC : OP_READ_DESC;
				if (op == OP_INSERT)
					offer_item(op, pick_value($urandom_range(99) < 20));
				else if (op == OP_DELETE)
					offer_item(op, pick_value($urandom_range(99) < 60));
				else
					offer_item(op, $urandom());
			end
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_full_table();
		test_backpressure();
		test_random();
		set_idling(0, 0);
		wait_drained();
		repeat (SETTLE_CYC) @(negedge clk);
		if (fail_count == 0 && pending_results.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
